/* hw/rtl/ggfe_pkg.sv */
// ----------------------------------------------------------------------------
// ggfe_pkg
// Shared constants, operation codes, types and the wire select function of the
// gate genome fitness evaluator.
// ----------------------------------------------------------------------------
package ggfe_pkg;

  // Genome and scoring constants.
  localparam int unsigned GateCount    = 20;
  localparam int unsigned TestLimit    = 64;
  localparam int unsigned NumWires     = 5;
  localparam int unsigned ScoreW       = 9;
  localparam int unsigned ScoreCap     = NumWires * TestLimit;
  localparam int unsigned PerfectReset = 130;

  // Field widths.
  localparam int unsigned GateIdxW = 5;
  localparam int unsigned SrcW     = 3;
  localparam int unsigned OpW      = 3;
  localparam int unsigned EntryW   = 2 * SrcW + OpW;
  localparam int unsigned MatchW   = 3;

  // Gate operation codes.
  localparam logic [OpW-1:0] OpCopy = 3'd0;
  localparam logic [OpW-1:0] OpNot  = 3'd1;
  localparam logic [OpW-1:0] OpOr   = 3'd2;
  localparam logic [OpW-1:0] OpAnd  = 3'd3;
  localparam logic [OpW-1:0] OpXor  = 3'd4;

  // Request kinds carried on tuser.
  localparam logic ReqGateWrite = 1'b0;
  localparam logic ReqTest      = 1'b1;

  // Status of the evaluation engine as seen by the top level.
  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_status_t;

  // One stored gate: source a, source b and operation.
  typedef struct packed {
    logic [SrcW-1:0] src_a;
    logic [SrcW-1:0] src_b;
    logic [OpW-1:0]  op;
  } gate_entry_t;

  // Reads one wire; indices beyond the last wire read as zero.
  function automatic logic wire_sel(input logic [NumWires-1:0] wires,
                                    input logic [SrcW-1:0] idx);
    logic bit_val;
    bit_val = 1'b0;
    for (int i = 0; i < NumWires; i++) begin
      if (idx == SrcW'(i)) begin
        bit_val = wires[i];
      end
    end
    return bit_val;
  endfunction

endpackage

/* hw/rtl/ggfe_eval_engine.sv */
// ----------------------------------------------------------------------------
// ggfe_eval_engine
// Holds the gate genome in a synchronous memory and runs it over one test
// vector, one gate per cycle, on a register of five wires.
// ----------------------------------------------------------------------------
module ggfe_eval_engine #(
  parameter int unsigned GATE_COUNT = ggfe_pkg::GateCount
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Gate write
  input  logic                            gate_we_i,
  input  logic [ggfe_pkg::GateIdxW-1:0]   gate_idx_i,
  input  ggfe_pkg::gate_entry_t           gate_data_i,
  // Test start and result handoff
  input  logic                            start_i,
  input  logic [ggfe_pkg::NumWires-1:0]   test_inputs_i,
  input  logic                            res_take_i,
  output ggfe_pkg::eng_status_t           status_o,
  output logic [ggfe_pkg::NumWires-1:0]   wires_o
);

  localparam int unsigned AddrW = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
  localparam logic [AddrW-1:0] LastGate = AddrW'(GATE_COUNT - 1);
  localparam logic [2:0] LastDst = 3'(ggfe_pkg::NumWires - 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } eng_state_e;

  eng_state_e state_q, state_d;
  logic [AddrW-1:0] gate_cnt_q, gate_cnt_d;
  logic [2:0]       dst_q, dst_d;
  logic [ggfe_pkg::NumWires-1:0] wires_q, wires_d;

  ggfe_pkg::gate_entry_t gate_mem [GATE_COUNT];
  ggfe_pkg::gate_entry_t rd_q;
  logic [AddrW-1:0]      rd_addr;
  logic                  is_last;
  logic                  op_a, op_b;

  // Gate memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (gate_we_i) begin
      gate_mem[AddrW'(gate_idx_i)] <= gate_data_i;
    end
    rd_q <= gate_mem[rd_addr];
  end

  assign is_last = (gate_cnt_q == LastGate);

  // Read ahead one gate; the first gate is fetched while idle.
  always_comb begin
    if (state_q == StRun && !is_last) begin
      rd_addr = gate_cnt_q + AddrW'(1);
    end else begin
      rd_addr = '0;
    end
  end

  assign op_a = ggfe_pkg::wire_sel(wires_q, rd_q.src_a);
  assign op_b = ggfe_pkg::wire_sel(wires_q, rd_q.src_b);

  // Sequencer and gate evaluation.
  always_comb begin
    state_d    = state_q;
    gate_cnt_d = gate_cnt_q;
    dst_d      = dst_q;
    wires_d    = wires_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          wires_d    = test_inputs_i;
          gate_cnt_d = '0;
          dst_d      = '0;
          state_d    = StRun;
        end
      end
      StRun: begin
        unique case (rd_q.op)
          ggfe_pkg::OpCopy: wires_d[dst_q] = op_a;
          ggfe_pkg::OpNot:  wires_d[dst_q] = ~op_a;
          ggfe_pkg::OpOr:   wires_d[dst_q] = op_a | op_b;
          ggfe_pkg::OpAnd:  wires_d[dst_q] = op_a & op_b;
          ggfe_pkg::OpXor:  wires_d[dst_q] = op_a ^ op_b;
          default:          wires_d = wires_q;
        endcase
        dst_d      = (dst_q == LastDst) ? 3'd0 : dst_q + 3'd1;
        gate_cnt_d = gate_cnt_q + AddrW'(1);
        if (is_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (res_take_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gate_cnt_q <= gate_cnt_d;
    dst_q      <= dst_d;
    wires_q    <= wires_d;
  end

  assign status_o.idle      = (state_q == StIdle);
  assign status_o.res_valid = (state_q == StDone);
  assign wires_o            = wires_q;

endmodule

/* hw/rtl/gate_genome_fitness_eval_core.sv */
// ----------------------------------------------------------------------------
// gate_genome_fitness_eval_core
// Loads a genome of gates and scores it against test vectors, accumulating a
// saturating score per genome.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake          Contents
//  s_axis    in   tvalid/tready      gate write (tuser 0) or test vector (tuser 1)
//  m_axis    out  tvalid/tready      one result word per test vector
//  cfg       in   cfg_wr_en_i        perfect score register, no read-back
//
//  A gate write to an index below GATE_COUNT stores the gate. A test vector
//  loads the wires, reads each gate from the gate memory and evaluates it in
//  turn, and then hands the result to the output register.
//  The result register frees the input side; a full, stalled result register
//  holds the engine until it is taken. Reset clears the score to zero and
//  sets the perfect score to 130; the gate memory is undefined until written.
// ----------------------------------------------------------------------------
module gate_genome_fitness_eval_core #(
  parameter int unsigned GATE_COUNT = ggfe_pkg::GateCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [4:0] gate_index, [7:5] source_a, [10:8] source_b, [13:11] gate_op,
  // [18:14] test_inputs, [23:19] expected_outputs
  input  logic [23:0] s_axis_tdata_i,
  // [0] req_type
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [4:0] circuit_outputs, [7:5] bit_matches, [16:8] running_score,
  // [17] perfect, [23:18] zero
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  // Configuration
  input  logic        cfg_wr_en_i,
  input  logic [8:0]  cfg_wr_data_i
);

  localparam int unsigned NW = ggfe_pkg::NumWires;
  localparam int unsigned SW = ggfe_pkg::ScoreW;
  localparam int unsigned MW = ggfe_pkg::MatchW;

  // Input field unpacking.
  logic [ggfe_pkg::GateIdxW-1:0] in_gate_idx;
  ggfe_pkg::gate_entry_t         in_entry;
  logic [NW-1:0]                 in_test, in_exp;
  logic                          in_accept;

  assign in_gate_idx    = s_axis_tdata_i[4:0];
  assign in_entry.src_a = s_axis_tdata_i[7:5];
  assign in_entry.src_b = s_axis_tdata_i[10:8];
  assign in_entry.op    = s_axis_tdata_i[13:11];
  assign in_test        = s_axis_tdata_i[18:14];
  assign in_exp         = s_axis_tdata_i[23:19];

  ggfe_pkg::eng_status_t eng_status;
  logic [NW-1:0]         eng_wires;
  logic                  gate_we, start, res_take;

  assign s_axis_tready_o = eng_status.idle;
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;
  assign gate_we  = in_accept && (s_axis_tuser_i == ggfe_pkg::ReqGateWrite)
                    && (int'(in_gate_idx) < GATE_COUNT);
  assign start    = in_accept && (s_axis_tuser_i == ggfe_pkg::ReqTest);

  // Result register is free when empty or drained this cycle.
  logic out_valid_q, out_valid_d;
  assign res_take = eng_status.res_valid & (~out_valid_q | m_axis_tready_i);

  ggfe_eval_engine #(
    .GATE_COUNT(GATE_COUNT)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gate_we_i    (gate_we),
    .gate_idx_i   (in_gate_idx),
    .gate_data_i  (in_entry),
    .start_i      (start),
    .test_inputs_i(in_test),
    .res_take_i   (res_take),
    .status_o     (eng_status),
    .wires_o      (eng_wires)
  );

  // Expected bits and last flag of the test in flight.
  logic [NW-1:0] exp_q;
  logic          last_q;

  always_ff @(posedge clk_i) begin
    if (start) begin
      exp_q  <= in_exp;
      last_q <= s_axis_tlast_i;
    end
  end

  // Match count over the five wires.
  logic [MW-1:0] match_cnt;
  logic [NW-1:0] eq_bits;

  always_comb begin
    eq_bits = ~(eng_wires ^ exp_q);
    match_cnt = '0;
    for (int i = 0; i < NW; i++) begin
      match_cnt = match_cnt + MW'(eq_bits[i]);
    end
  end

  // Saturating score update.
  logic [SW-1:0] score_q, score_d, perfect_q;
  logic [SW:0]   score_sum;
  logic [SW-1:0] score_sat;

  assign score_sum = {1'b0, score_q} + (SW + 1)'(match_cnt);
  assign score_sat = (score_sum > (SW + 1)'(ggfe_pkg::ScoreCap))
                     ? SW'(ggfe_pkg::ScoreCap) : score_sum[SW-1:0];

  always_comb begin
    score_d = score_q;
    if (res_take) begin
      score_d = last_q ? '0 : score_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q   <= '0;
      perfect_q <= SW'(ggfe_pkg::PerfectReset);
    end else begin
      score_q <= score_d;
      if (cfg_wr_en_i) begin
        perfect_q <= cfg_wr_data_i;
      end
    end
  end

  // Output register.
  logic [NW-1:0] out_wires_q;
  logic [MW-1:0] out_matches_q;
  logic [SW-1:0] out_score_q;
  logic          out_perfect_q, out_last_q;

  assign out_valid_d = res_take | (out_valid_q & ~m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_wires_q   <= eng_wires;
      out_matches_q <= match_cnt;
      out_score_q   <= score_sat;
      out_perfect_q <= (score_sat == perfect_q);
      out_last_q    <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_perfect_q, out_score_q, out_matches_q, out_wires_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
